>>> src/ptd_pkg.sv
// ---------------------------------------------------------------------------
// ptd_pkg
// shared constants, codes and control structs of the periodic task dispatcher
// ---------------------------------------------------------------------------
package ptd_pkg;

   localparam int MAX_TASKS = 16;
   localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);

   localparam int OP_W      = 2;
   localparam int TIME_W    = 32;
   localparam int KIND_W    = 2;
   localparam int TIDX_W    = 4;
   localparam int HELD_W    = 5;

   localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
   localparam logic [OP_W-1:0] OP_STATS = 2'd2;

   localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DUE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SUM = 2'd2;

   typedef struct packed {
      logic capture;
      logic add;
      logic tick;
      logic advance;
      logic summary;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            total_zero;
      logic            due;
      logic            last;
      logic            out_free;
   } stat_type;

endpackage

>>> src/ptd_req_if.sv
// ---------------------------------------------------------------------------
// ptd_req_if
// request channel: task add, tick and statistics beats
// ---------------------------------------------------------------------------
interface ptd_req_if;

   logic                         valid;
   logic                         ready;
   logic [ptd_pkg::OP_W-1:0]     op;
   logic [ptd_pkg::TIME_W-1:0]   now;
   logic [ptd_pkg::TIME_W-1:0]   period;
   logic [ptd_pkg::TIME_W-1:0]   first_due;

   modport source (output valid, op, now, period, first_due, input ready);
   modport sink   (input valid, op, now, period, first_due, output ready);

endinterface

>>> src/ptd_rsp_if.sv
// ---------------------------------------------------------------------------
// ptd_rsp_if
// response channel: add replies, due tasks and summaries
// ---------------------------------------------------------------------------
interface ptd_rsp_if;

   logic                         valid;
   logic                         ready;
   logic [ptd_pkg::KIND_W-1:0]   kind;
   logic [ptd_pkg::TIDX_W-1:0]   task_index;
   logic                         accepted;
   logic [ptd_pkg::TIME_W-1:0]   tick_count;
   logic [ptd_pkg::TIME_W-1:0]   dispatch_count;
   logic [ptd_pkg::HELD_W-1:0]   tasks_held;
   logic                         final_res;

   modport source (output valid, kind, task_index, accepted, tick_count,
                   dispatch_count, tasks_held, final_res, input ready);
   modport sink   (input valid, kind, task_index, accepted, tick_count,
                   dispatch_count, tasks_held, final_res, output ready);

endinterface

>>> src/periodic_task_dispatcher_core.sv
// ---------------------------------------------------------------------------
// periodic_task_dispatcher_core
// periodic task table with add, tick scan and statistics readout
//
//   channel   dir   handshake     payload
//   req_chan  in    valid/ready   op, now, period, first_due
//   rsp_chan  out   valid/ready   kind, task_index, accepted, tick_count,
//                                 dispatch_count, tasks_held, final_res
//
// one request at a time; a tick scans the table one task per cycle
// a due task whose beat cannot leave holds the scan until rsp_chan frees up
// the next request is taken once the final beat sits in the output register
// synchronous reset clears counters and task count; tables need no clearing
// ---------------------------------------------------------------------------
module periodic_task_dispatcher_core (
   input  logic        clock,
   input  logic        reset,
   ptd_req_if.sink     req_chan,
   ptd_rsp_if.source   rsp_chan
);

   ptd_pkg::cmd_type   cmd;
   ptd_pkg::stat_type  stat;
   logic               req_ready;

   assign req_chan.ready = req_ready;

   ptd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptd_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_op        (req_chan.op),
      .req_now       (req_chan.now),
      .req_period    (req_chan.period),
      .req_first_due (req_chan.first_due),
      .cmd           (cmd),
      .stat          (stat),
      .rsp           (rsp_chan)
   );

endmodule

>>> src/ptd_ctrl.sv
// ---------------------------------------------------------------------------
// ptd_ctrl
// sequencer: request decode, task scan and result ordering
// ---------------------------------------------------------------------------
module ptd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ptd_pkg::stat_type  stat,
   output ptd_pkg::cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ADD,
      ST_TICK,
      ST_SCAN,
      ST_SUM
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (stat.op)
               ptd_pkg::OP_ADD:   state_in = ST_ADD;
               ptd_pkg::OP_TICK:  state_in = ST_TICK;
               ptd_pkg::OP_STATS: state_in = ST_SUM;
               default:           state_in = ST_IDLE;
            endcase
         end
         ST_ADD: begin
            if (stat.out_free) begin
               cmd.add  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_TICK: begin
            cmd.tick = 1'b1;
            state_in = stat.total_zero ? ST_SUM : ST_SCAN;
         end
         ST_SCAN: begin
            if (!stat.due || stat.out_free) begin
               cmd.advance = 1'b1;
               if (stat.last) begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            if (stat.out_free) begin
               cmd.summary = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/ptd_dp.sv
// ---------------------------------------------------------------------------
// ptd_dp
// datapath: task tables, counters, due test and response register
// ---------------------------------------------------------------------------
module ptd_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ptd_pkg::OP_W-1:0]      req_op,
   input  logic [ptd_pkg::TIME_W-1:0]    req_now,
   input  logic [ptd_pkg::TIME_W-1:0]    req_period,
   input  logic [ptd_pkg::TIME_W-1:0]    req_first_due,
   input  ptd_pkg::cmd_type              cmd,
   output ptd_pkg::stat_type             stat,
   ptd_rsp_if.source                     rsp
);

   logic [ptd_pkg::OP_W-1:0]     op_ff;
   logic [ptd_pkg::TIME_W-1:0]   now_ff;
   logic [ptd_pkg::TIME_W-1:0]   period_ff;
   logic [ptd_pkg::TIME_W-1:0]   first_ff;

   logic [ptd_pkg::CNT_W-1:0]    total_ff;
   logic [ptd_pkg::TIME_W-1:0]   ticks_ff;
   logic [ptd_pkg::TIME_W-1:0]   disp_ff;
   logic [ptd_pkg::IDX_W-1:0]    idx_ff;
   logic [ptd_pkg::IDX_W-1:0]    idx_in;

   logic [ptd_pkg::TIME_W-1:0]   per_mem [ptd_pkg::MAX_TASKS];
   logic [ptd_pkg::TIME_W-1:0]   due_mem [ptd_pkg::MAX_TASKS];
   logic [ptd_pkg::TIME_W-1:0]   per_rd_ff;
   logic [ptd_pkg::TIME_W-1:0]   due_rd_ff;

   logic                         valid_ff;
   logic [ptd_pkg::KIND_W-1:0]   kind_ff;
   logic [ptd_pkg::TIDX_W-1:0]   tidx_ff;
   logic                         acc_ff;
   logic [ptd_pkg::TIME_W-1:0]   oticks_ff;
   logic [ptd_pkg::TIME_W-1:0]   odisp_ff;
   logic [ptd_pkg::HELD_W-1:0]   oheld_ff;
   logic                         final_ff;

   logic                         full;
   logic                         per_zero;
   logic [ptd_pkg::TIME_W-1:0]   diff;
   logic                         due;
   logic                         last;
   logic                         dispatch;
   logic                         add_ok;
   logic [ptd_pkg::IDX_W-1:0]    slot;
   logic [ptd_pkg::CNT_W-1:0]    total_inc;
   logic [ptd_pkg::TIME_W-1:0]   disp_inc;
   logic                         due_we;
   logic [ptd_pkg::IDX_W-1:0]    due_wa;
   logic [ptd_pkg::TIME_W-1:0]   due_wd;

   assign full      = (total_ff == ptd_pkg::CNT_W'(ptd_pkg::MAX_TASKS));
   assign per_zero  = (per_rd_ff == '0);
   assign diff      = now_ff - due_rd_ff;
   assign due       = per_zero || !diff[ptd_pkg::TIME_W-1];
   assign last      = ((ptd_pkg::CNT_W'(idx_ff) + ptd_pkg::CNT_W'(1)) == total_ff);
   assign dispatch  = cmd.advance && due;
   assign add_ok    = cmd.add && !full;
   assign slot      = ptd_pkg::IDX_W'(total_ff);
   assign total_inc = total_ff + ptd_pkg::CNT_W'(1);
   assign disp_inc  = disp_ff + ptd_pkg::TIME_W'(1);

   assign due_we = add_ok || (dispatch && !per_zero);
   assign due_wa = cmd.add ? slot : idx_ff;
   assign due_wd = cmd.add ? first_ff : (now_ff + per_rd_ff);

   assign stat.op         = op_ff;
   assign stat.total_zero = (total_ff == '0);
   assign stat.due        = due;
   assign stat.last       = last;
   assign stat.out_free   = !valid_ff || rsp.ready;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.tick) begin
         idx_in = '0;
      end else if (cmd.advance) begin
         idx_in = idx_ff + ptd_pkg::IDX_W'(1);
      end
   end

   // input capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_op;
         now_ff    <= req_now;
         period_ff <= req_period;
         first_ff  <= req_first_due;
      end
   end

   // task tables
   always_ff @(posedge clock) begin
      if (add_ok) begin
         per_mem[slot] <= period_ff;
      end
      if (due_we) begin
         due_mem[due_wa] <= due_wd;
      end
      per_rd_ff <= per_mem[idx_in];
      due_rd_ff <= due_mem[idx_in];
   end

   // counters and scan index
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         ticks_ff <= '0;
         disp_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         idx_ff <= idx_in;
         if (add_ok) begin
            total_ff <= total_inc;
         end
         if (cmd.tick) begin
            ticks_ff <= ticks_ff + ptd_pkg::TIME_W'(1);
         end
         if (dispatch) begin
            disp_ff <= disp_inc;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.add || dispatch || cmd.summary) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add) begin
         kind_ff   <= ptd_pkg::KIND_ADD;
         tidx_ff   <= add_ok ? ptd_pkg::TIDX_W'(slot) : '0;
         acc_ff    <= add_ok;
         oticks_ff <= ticks_ff;
         odisp_ff  <= disp_ff;
         oheld_ff  <= ptd_pkg::HELD_W'(add_ok ? total_inc : total_ff);
         final_ff  <= 1'b1;
      end else if (dispatch) begin
         kind_ff   <= ptd_pkg::KIND_DUE;
         tidx_ff   <= ptd_pkg::TIDX_W'(idx_ff);
         acc_ff    <= 1'b0;
         oticks_ff <= ticks_ff;
         odisp_ff  <= disp_inc;
         oheld_ff  <= ptd_pkg::HELD_W'(total_ff);
         final_ff  <= 1'b0;
      end else if (cmd.summary) begin
         kind_ff   <= ptd_pkg::KIND_SUM;
         tidx_ff   <= '0;
         acc_ff    <= 1'b0;
         oticks_ff <= ticks_ff;
         odisp_ff  <= disp_ff;
         oheld_ff  <= ptd_pkg::HELD_W'(total_ff);
         final_ff  <= 1'b1;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.kind           = kind_ff;
   assign rsp.task_index     = tidx_ff;
   assign rsp.accepted       = acc_ff;
   assign rsp.tick_count     = oticks_ff;
   assign rsp.dispatch_count = odisp_ff;
   assign rsp.tasks_held     = oheld_ff;
   assign rsp.final_res      = final_ff;

endmodule

>>> sim/ptd_checker.sv
// ---------------------------------------------------------------------------
// ptd_checker
// watches both channels of the periodic task dispatcher, predicts each
// response beat from accepted requests and compares them field by field
// ---------------------------------------------------------------------------
module ptd_checker (
   input  logic   clock,
   input  logic   reset,
   ptd_req_if     req_chan,
   ptd_rsp_if     rsp_chan,
   output int     err_count,
   output int     beats_owed
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [ptd_pkg::KIND_W-1:0] kind;
      logic [ptd_pkg::TIDX_W-1:0] task_index;
      logic                       accepted;
      logic [ptd_pkg::TIME_W-1:0] tick_count;
      logic [ptd_pkg::TIME_W-1:0] dispatch_count;
      logic [ptd_pkg::HELD_W-1:0] tasks_held;
      logic                       final_res;
   } rsp_beat_type;

   logic [ptd_pkg::TIME_W-1:0] period_tbl [ptd_pkg::MAX_TASKS];
   logic [ptd_pkg::TIME_W-1:0] due_tbl    [ptd_pkg::MAX_TASKS];
   logic [ptd_pkg::HELD_W-1:0] task_cnt;
   logic [ptd_pkg::TIME_W-1:0] tick_ctr;
   logic [ptd_pkg::TIME_W-1:0] disp_ctr;

   rsp_beat_type owed_beats [$];
   rsp_beat_type got_beat;
   rsp_beat_type exp_beat;

   function automatic string beat_text(input rsp_beat_type b);
      return $sformatf("kind=%0d idx=%0d acc=%0d ticks=%0d disp=%0d held=%0d last=%0d",
                       b.kind, b.task_index, b.accepted, b.tick_count,
                       b.dispatch_count, b.tasks_held, b.final_res);
   endfunction

   function automatic void owe_beat(input logic [ptd_pkg::KIND_W-1:0] kind,
                                    input logic [ptd_pkg::TIDX_W-1:0] idx,
                                    input logic acc, input logic last);
      rsp_beat_type b;
      b.kind           = kind;
      b.task_index     = idx;
      b.accepted       = acc;
      b.tick_count     = tick_ctr;
      b.dispatch_count = disp_ctr;
      b.tasks_held     = task_cnt;
      b.final_res      = last;
      owed_beats.push_back(b);
   endfunction

   function automatic void run_scheduler(input logic [ptd_pkg::OP_W-1:0] op,
                                         input logic [ptd_pkg::TIME_W-1:0] t_now,
                                         input logic [ptd_pkg::TIME_W-1:0] per,
                                         input logic [ptd_pkg::TIME_W-1:0] first);
      logic [ptd_pkg::TIME_W-1:0] diff;
      logic [ptd_pkg::IDX_W-1:0]  ix;
      case (op)
         ptd_pkg::OP_ADD: begin
            if (task_cnt < ptd_pkg::HELD_W'(ptd_pkg::MAX_TASKS)) begin
               ix             = task_cnt[ptd_pkg::IDX_W-1:0];
               period_tbl[ix] = per;
               due_tbl[ix]    = first;
               task_cnt       = task_cnt + 1'b1;
               owe_beat(ptd_pkg::KIND_ADD, ptd_pkg::TIDX_W'(ix), 1'b1, 1'b1);
            end else begin
               owe_beat(ptd_pkg::KIND_ADD, '0, 1'b0, 1'b1);
            end
         end
         ptd_pkg::OP_TICK: begin
            tick_ctr = tick_ctr + 1'b1;
            for (int i = 0; i < ptd_pkg::MAX_TASKS; i++) begin
               ix = ptd_pkg::IDX_W'(i);
               if (ptd_pkg::HELD_W'(i) < task_cnt) begin
                  diff = t_now - due_tbl[ix];
                  if (period_tbl[ix] == '0 || !diff[ptd_pkg::TIME_W-1]) begin
                     if (period_tbl[ix] != '0)
                        due_tbl[ix] = t_now + period_tbl[ix];
                     disp_ctr = disp_ctr + 1'b1;
                     owe_beat(ptd_pkg::KIND_DUE, ptd_pkg::TIDX_W'(ix), 1'b0, 1'b0);
                  end
               end
            end
            owe_beat(ptd_pkg::KIND_SUM, '0, 1'b0, 1'b1);
         end
         ptd_pkg::OP_STATS: begin
            owe_beat(ptd_pkg::KIND_SUM, '0, 1'b0, 1'b1);
         end
         default: begin
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         task_cnt   = '0;
         tick_ctr   = '0;
         disp_ctr   = '0;
         err_count  = 0;
         beats_owed = 0;
         owed_beats.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got_beat.kind           = rsp_chan.kind;
            got_beat.task_index     = rsp_chan.task_index;
            got_beat.accepted       = rsp_chan.accepted;
            got_beat.tick_count     = rsp_chan.tick_count;
            got_beat.dispatch_count = rsp_chan.dispatch_count;
            got_beat.tasks_held     = rsp_chan.tasks_held;
            got_beat.final_res      = rsp_chan.final_res;
            if (owed_beats.size() == 0) begin
               err_count++;
               if (err_count <= 10)
                  $display("%0t unexpected beat %s", $realtime, beat_text(got_beat));
            end else begin
               exp_beat = owed_beats.pop_front();
               if (got_beat.kind !== exp_beat.kind ||
                   got_beat.task_index !== exp_beat.task_index ||
                   got_beat.accepted !== exp_beat.accepted ||
                   got_beat.tick_count !== exp_beat.tick_count ||
                   got_beat.dispatch_count !== exp_beat.dispatch_count ||
                   got_beat.tasks_held !== exp_beat.tasks_held ||
                   got_beat.final_res !== exp_beat.final_res) begin
                  err_count++;
                  if (err_count <= 10) begin
                     $display("%0t mismatch exp %s", $realtime, beat_text(exp_beat));
                     $display("%0t          got %s", $realtime, beat_text(got_beat));
                  end
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            run_scheduler(req_chan.op, req_chan.now, req_chan.period,
                          req_chan.first_due);
         beats_owed = owed_beats.size();
      end
   end

endmodule

>>> sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the periodic task dispatcher: a directed pass over
// wrap-safe due times, zero and full-range periods and the empty table, then
// random adds, ticks and stats reads that fill the table and keep refusing
// adds, with random gaps and backpressure on both channels
// ---------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [ptd_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 280;
   localparam int MAX_WAIT     = 18;
   localparam int DRAIN_CYCLES = 40;

   logic clock;
   logic reset;
   int   chk_errors;
   int   chk_owed;

   int   req_run_left;
   bit   req_calm;
   int   rsp_run_left;
   bit   rsp_calm;
   int   rsp_hold;
   logic [ptd_pkg::TIME_W-1:0] cur_time;

   ptd_req_if req_chan ();
   ptd_rsp_if rsp_chan ();

   periodic_task_dispatcher_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ptd_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .err_count  (chk_errors),
      .beats_owed (chk_owed)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #5000000;
      $display("DONE: errors detected");
      $finish;
   end

   // each run of beats is drawn at random as back-to-back or with random waits
   function automatic int draw_wait(inout int run_left, inout bit calm);
      if (run_left == 0) begin
         run_left = $urandom_range(10, 40);
         calm     = ($urandom_range(0, 2) == 0);
      end
      run_left--;
      return calm ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold       <= 0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         int n;
         n = draw_wait(rsp_run_left, rsp_calm);
         rsp_hold       <= n;
         rsp_chan.ready <= (n == 0);
      end else if (rsp_hold != 0) begin
         rsp_hold       <= rsp_hold - 1;
         rsp_chan.ready <= (rsp_hold == 1);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic send_beat(input logic [ptd_pkg::OP_W-1:0] op,
                            input logic [ptd_pkg::TIME_W-1:0] t_now,
                            input logic [ptd_pkg::TIME_W-1:0] per,
                            input logic [ptd_pkg::TIME_W-1:0] first);
      int gap;
      gap = draw_wait(req_run_left, req_calm);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.op        <= op;
      req_chan.now       <= t_now;
      req_chan.period    <= per;
      req_chan.first_due <= first;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_random_add();
      logic [ptd_pkg::TIME_W-1:0] per;
      logic [ptd_pkg::TIME_W-1:0] first;
      case ($urandom_range(0, 9))
         0:       per = '0;
         1:       per = $urandom;
         default: per = $urandom_range(1, 60);
      endcase
      if ($urandom_range(0, 9) == 0)
         first = $urandom;
      else
         first = cur_time + $urandom_range(0, 60);
      send_beat(ptd_pkg::OP_ADD, $urandom, per, first);
   endtask

   task automatic send_random_tick();
      if ($urandom_range(0, 19) == 0)
         cur_time = $urandom;
      else
         cur_time = cur_time + $urandom_range(0, 40);
      send_beat(ptd_pkg::OP_TICK, cur_time, $urandom, $urandom);
   endtask

   initial begin
      int sent;
      int pick;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.op        <= ptd_pkg::OP_ADD;
      req_chan.now       <= '0;
      req_chan.period    <= '0;
      req_chan.first_due <= '0;
      req_run_left       = 0;
      req_calm           = 1'b0;
      cur_time           = '0;
      sent               = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, ignored code, then boundary tasks
      send_beat(ptd_pkg::OP_STATS, '0, '0, '0);
      send_beat(ptd_pkg::OP_TICK, '0, '1, '1);
      send_beat(OP_UNUSED, '1, '1, '1);
      send_beat(ptd_pkg::OP_ADD, '1, '0, '1);
      send_beat(ptd_pkg::OP_ADD, '0, '1, '0);
      send_beat(ptd_pkg::OP_ADD, '0, 32'd5, 32'h8000_0000);
      send_beat(ptd_pkg::OP_ADD, '0, 32'd1, 32'd10);
      // wrap-safe due test on both sides of half range
      send_beat(ptd_pkg::OP_TICK, 32'h0000_0000, '0, '0);
      send_beat(ptd_pkg::OP_TICK, 32'hFFFF_FFFF, '0, '0);
      send_beat(ptd_pkg::OP_TICK, 32'h7FFF_FFFF, '0, '0);
      send_beat(ptd_pkg::OP_TICK, 32'hFFFF_FFFE, '0, '0);
      send_beat(ptd_pkg::OP_TICK, 32'd10, '0, '0);
      send_beat(ptd_pkg::OP_TICK, 32'd11, '0, '0);
      send_beat(ptd_pkg::OP_STATS, '1, '1, '1);
      cur_time = 32'd11;

      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            send_random_add();
            sent++;
         end else if (pick < 80) begin
            send_random_tick();
            sent++;
         end else if (pick < 92) begin
            send_beat(ptd_pkg::OP_STATS, $urandom, $urandom, $urandom);
            sent++;
         end else begin
            send_beat(OP_UNUSED, $urandom, $urandom, $urandom);
         end
      end
      req_chan.valid <= 1'b0;

      do @(negedge clock); while (chk_owed != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (chk_errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
